>>> sv/elfmap_pkg.sv
// shared types, constants and codes of the elf segment mapping planner
// no dependencies; used by elfmap_calc and elf_segment_mapping_planner
package elfmap_pkg;

   // mapping table limit and width of the mapping count
   localparam int MAX_MAPPINGS = 64;
   localparam int MAP_CNT_W    = $clog2(MAX_MAPPINGS + 1);

   // stream payload widths
   localparam int REQ_DATA_W = 520;
   localparam int RSP_DATA_W = 392;

   // configuration register indexes
   localparam logic CSR_LOAD_BIAS   = 1'b0;
   localparam logic CSR_SOURCE_KIND = 1'b1;

   // permission bits of the segment flags
   localparam logic [2:0] FLAG_READ  = 3'h4;
   localparam logic [2:0] FLAG_WRITE = 3'h2;
   localparam logic [2:0] FLAG_EXEC  = 3'h1;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_OVERFLOW = 2'd1,
      STATUS_RANGE    = 2'd2,
      STATUS_FULL     = 2'd3
   } status_type;

   typedef struct packed {
      logic        start_layout;
      logic [63:0] seg_vaddr;
      logic [63:0] seg_mem_size;
      logic [63:0] seg_file_size;
      logic [63:0] seg_file_offset;
      logic [63:0] seg_map_start;
      logic [63:0] seg_map_size;
      logic [63:0] seg_map_offset;
      logic [63:0] seg_map_align;
      logic [2:0]  seg_flags;
      logic        last_segment;
   } item_type;

   typedef struct packed {
      logic [63:0] map_addr;
      logic [63:0] map_len;
      logic [63:0] map_file_offset;
      logic [63:0] map_file_bytes;
      logic [63:0] zero_fill_addr;
      logic [63:0] zero_fill_len;
      logic [2:0]  protection;
      logic        anonymous;
      logic        origin_tag;
      status_type  status;
      logic        last_of_segment;
      logic        plan_end;
   } result_type;

   typedef struct packed {
      result_type           res0;
      result_type           res1;
      logic                 two_results;
      logic [MAP_CNT_W-1:0] new_total;
   } calc_type;

endpackage

>>> sv/elfmap_calc.sv
// combinational planner: turns one segment into one or two mapping words
// depends on elfmap_pkg
module elfmap_calc (
   input  elfmap_pkg::item_type              item,
   input  logic [elfmap_pkg::MAP_CNT_W-1:0]  total,
   input  logic [63:0]                       addr_bias,
   input  logic                              source_kind,
   output elfmap_pkg::calc_type              calc
);

   logic [elfmap_pkg::MAP_CNT_W-1:0] total_used;
   logic [elfmap_pkg::MAP_CNT_W-1:0] total_p1;
   logic [64:0] seg_end_s, bss_sum_s, fdata_end_s, fme_sum_s;
   logic [64:0] addr_s, zaddr_s, baddr_s;
   logic [63:0] m, bss_end, fme, zlen;
   logic        pow2, err_mem, err_file, err_range, full0, full1;
   logic [2:0]  prot;
   elfmap_pkg::result_type blank, fail0, fail1;

   // shared sums and alignment
   always_comb begin
      total_used  = item.start_layout ? '0 : total;
      total_p1    = total_used + elfmap_pkg::MAP_CNT_W'(1);
      m           = item.seg_map_align - 64'd1;
      pow2        = (item.seg_map_align != 64'd0) && ((item.seg_map_align & m) == 64'd0);
      seg_end_s   = {1'b0, item.seg_vaddr} + {1'b0, item.seg_mem_size};
      bss_sum_s   = {1'b0, seg_end_s[63:0]} + {1'b0, m};
      bss_end     = bss_sum_s[63:0] & ~m;
      fdata_end_s = {1'b0, item.seg_vaddr} + {1'b0, item.seg_file_size};
      fme_sum_s   = {1'b0, fdata_end_s[63:0]} + {1'b0, m};
      fme         = fme_sum_s[63:0] & ~m;
      addr_s      = {1'b0, addr_bias} + {1'b0, item.seg_map_start};
      zaddr_s     = {1'b0, addr_bias} + {1'b0, fdata_end_s[63:0]};
      baddr_s     = {1'b0, addr_bias} + {1'b0, fme};
      err_mem     = seg_end_s[64] || !pow2 || bss_sum_s[64];
      err_file    = fdata_end_s[64] || fme_sum_s[64];
      err_range   = (fme < item.seg_map_start) || (bss_end < fme);
      zlen        = ((item.seg_mem_size > item.seg_file_size) && (fme > fdata_end_s[63:0]))
                    ? (fme - fdata_end_s[63:0]) : 64'd0;
      full0       = total_used >= elfmap_pkg::MAP_CNT_W'(elfmap_pkg::MAX_MAPPINGS);
      full1       = total_p1 >= elfmap_pkg::MAP_CNT_W'(elfmap_pkg::MAX_MAPPINGS);
      prot        = {((item.seg_flags & elfmap_pkg::FLAG_EXEC) != 3'd0),
                     ((item.seg_flags & elfmap_pkg::FLAG_WRITE) != 3'd0),
                     ((item.seg_flags & elfmap_pkg::FLAG_READ) != 3'd0)};
   end

   // result words, chosen in check order
   always_comb begin
      blank                 = '0;
      blank.origin_tag      = source_kind;
      blank.status          = elfmap_pkg::STATUS_OK;
      fail0                 = blank;
      fail0.last_of_segment = 1'b1;
      fail0.plan_end        = item.last_segment;
      fail1                 = fail0;
      calc.res0             = blank;
      calc.res1             = blank;
      calc.two_results      = 1'b0;
      calc.new_total        = total_used;

      priority if (err_mem) begin
         fail0.status = elfmap_pkg::STATUS_OVERFLOW;
         calc.res0    = fail0;
      end else if (item.seg_file_size == 64'd0) begin
         priority if (addr_s[64]) begin
            fail0.status = elfmap_pkg::STATUS_OVERFLOW;
            calc.res0    = fail0;
         end else if (full0) begin
            fail0.status = elfmap_pkg::STATUS_FULL;
            calc.res0    = fail0;
         end else begin
            calc.res0.map_addr        = addr_s[63:0];
            calc.res0.map_len         = item.seg_map_size;
            calc.res0.protection      = prot;
            calc.res0.anonymous       = 1'b1;
            calc.res0.last_of_segment = 1'b1;
            calc.res0.plan_end        = item.last_segment;
            calc.new_total            = total_p1;
         end
      end else if (err_file || err_range || addr_s[64] || ((zlen != 64'd0) && zaddr_s[64])
                   || full0) begin
         priority if (err_file) fail0.status = elfmap_pkg::STATUS_OVERFLOW;
         else if (err_range)    fail0.status = elfmap_pkg::STATUS_RANGE;
         else if (addr_s[64] || ((zlen != 64'd0) && zaddr_s[64]))
                                fail0.status = elfmap_pkg::STATUS_OVERFLOW;
         else                   fail0.status = elfmap_pkg::STATUS_FULL;
         calc.res0 = fail0;
      end else begin
         // file-backed mapping
         calc.res0.map_addr        = addr_s[63:0];
         calc.res0.map_len         = fme - item.seg_map_start;
         calc.res0.map_file_offset = item.seg_map_offset;
         calc.res0.map_file_bytes  = item.seg_file_size
                                     + (item.seg_file_offset - item.seg_map_offset);
         calc.res0.zero_fill_addr  = (zlen != 64'd0) ? zaddr_s[63:0] : 64'd0;
         calc.res0.zero_fill_len   = zlen;
         calc.res0.protection      = prot;
         calc.new_total            = total_p1;
         if (bss_end > fme) begin
            // bss mapping or its error as a second word
            calc.two_results = 1'b1;
            priority if (baddr_s[64]) begin
               fail1.status = elfmap_pkg::STATUS_OVERFLOW;
               calc.res1    = fail1;
            end else if (full1) begin
               fail1.status = elfmap_pkg::STATUS_FULL;
               calc.res1    = fail1;
            end else begin
               calc.res1.map_addr        = baddr_s[63:0];
               calc.res1.map_len         = bss_end - fme;
               calc.res1.protection      = prot;
               calc.res1.anonymous       = 1'b1;
               calc.res1.last_of_segment = 1'b1;
               calc.res1.plan_end        = item.last_segment;
               calc.new_total            = total_p1 + elfmap_pkg::MAP_CNT_W'(1);
            end
         end else begin
            calc.res0.last_of_segment = 1'b1;
            calc.res0.plan_end        = item.last_segment;
         end
      end
   end

endmodule

>>> sv/elf_segment_mapping_planner.sv
// top level of the elf segment mapping planner: input register, result register, count
// depends on elfmap_pkg and elfmap_calc
//
// Use: each word on the req_ channel is one loadable segment; the block answers on
// the rsp_ channel with one or two mapping words per segment, the last one marked by
// rsp_tlast, and by rsp_tuser when it closes the last segment of a plan.
// csr_ writes set the load bias (index 0) and the origin tag (index 1); write them
// only while the block is idle.
// Flow: a segment accepted into the input register shows its first word on rsp_ once
// that word is loaded into the result register. Throughput: one word per cycle out of
// the result register while rsp_tready is high; a segment that gives two words holds
// the input register until both have gone, sequenced by the word phase.
// A new segment is taken in the cycle its predecessor hands over its final word,
// so back-to-back single-word segments run at one per cycle while rsp_tready is high.
// When the receiver stalls, the result register holds its word and the input
// register holds the segment; req_tready falls once both are occupied.
// Reset clears the mapping count, the valid flags of both registers, the word phase and the configuration to zero.
module elf_segment_mapping_planner (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration write port
   input  logic                                  csr_we,
   input  logic                                  csr_index,
   input  logic [63:0]                           csr_wdata,
   // segment input
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // seg_vaddr, seg_mem_size, seg_file_size, seg_file_offset, seg_map_start,
   // seg_map_size, seg_map_offset, seg_map_align, seg_flags, zero pad
   input  logic [elfmap_pkg::REQ_DATA_W-1:0]     req_tdata,
   // start_layout
   input  logic                                  req_tuser,
   // last_segment
   input  logic                                  req_tlast,
   // mapping output
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // map_addr, map_len, map_file_offset, map_file_bytes, zero_fill_addr,
   // zero_fill_len, protection, anonymous, origin_tag, status, zero pad
   output logic [elfmap_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // plan_end
   output logic                                  rsp_tuser,
   // last_of_segment
   output logic                                  rsp_tlast
);

   logic [63:0]                      addr_bias_ff;
   logic                             source_kind_ff;
   logic [elfmap_pkg::MAP_CNT_W-1:0] total_ff;
   elfmap_pkg::item_type             item_ff, item_in;
   logic                             item_valid_ff;
   logic                             phase_ff;
   elfmap_pkg::result_type           rsp_ff;
   logic                             rsp_valid_ff;
   elfmap_pkg::calc_type             calc;
   logic                             load_out, last_phase, retire;

   // unpack the input word
   always_comb begin
      item_in.start_layout    = req_tuser;
      item_in.seg_vaddr       = req_tdata[63:0];
      item_in.seg_mem_size    = req_tdata[127:64];
      item_in.seg_file_size   = req_tdata[191:128];
      item_in.seg_file_offset = req_tdata[255:192];
      item_in.seg_map_start   = req_tdata[319:256];
      item_in.seg_map_size    = req_tdata[383:320];
      item_in.seg_map_offset  = req_tdata[447:384];
      item_in.seg_map_align   = req_tdata[511:448];
      item_in.seg_flags       = req_tdata[514:512];
      item_in.last_segment    = req_tlast;
   end

   elfmap_calc u_calc (
      .item        (item_ff),
      .total       (total_ff),
      .addr_bias   (addr_bias_ff),
      .source_kind (source_kind_ff),
      .calc        (calc)
   );

   // handshake control
   assign load_out   = item_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign last_phase = !calc.two_results || phase_ff;
   assign retire     = load_out && last_phase;
   assign req_tready = !item_valid_ff || retire;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_bias_ff   <= '0;
         source_kind_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            elfmap_pkg::CSR_LOAD_BIAS:   addr_bias_ff   <= csr_wdata;
            elfmap_pkg::CSR_SOURCE_KIND: source_kind_ff <= csr_wdata[0];
            default:                     addr_bias_ff   <= addr_bias_ff;
         endcase
      end
   end

   // input register and word phase
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         phase_ff      <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            item_valid_ff <= 1'b1;
         end else if (retire) begin
            item_valid_ff <= 1'b0;
         end
         if (load_out) begin
            phase_ff <= !last_phase;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= item_in;
      end
   end

   // mapping count, committed when the segment retires
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else if (retire) begin
         total_ff <= calc.new_total;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_ff <= phase_ff ? calc.res1 : calc.res0;
      end
   end

   // pack the output word
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff.status, rsp_ff.origin_tag, rsp_ff.anonymous,
                        rsp_ff.protection, rsp_ff.zero_fill_len, rsp_ff.zero_fill_addr,
                        rsp_ff.map_file_bytes, rsp_ff.map_file_offset, rsp_ff.map_len,
                        rsp_ff.map_addr};
   assign rsp_tuser  = rsp_ff.plan_end;
   assign rsp_tlast  = rsp_ff.last_of_segment;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= elfmap_pkg::MAP_CNT_W'(elfmap_pkg::MAX_MAPPINGS))
      else $error("mapping count above table limit");

   a_phase_needs_item: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> item_valid_ff)
      else $error("second word pending without a segment");

   a_error_ends_segment: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.status != elfmap_pkg::STATUS_OK)) |-> rsp_ff.last_of_segment)
      else $error("error word does not close its segment");

   a_first_word_file: assert property (@(posedge clock) disable iff (reset)
      (load_out && !last_phase) |=> (!rsp_ff.anonymous && !rsp_ff.last_of_segment))
      else $error("first of two words is not a file-backed mapping");

endmodule
